[src/i5gsdp_pkg.sv]
package i5gsdp_pkg;

  localparam int WEIGHTS_PER_WORD = 8;
  localparam int WEIGHT_BITS      = 5;
  localparam int WORD_W           = 40;
  localparam int SCALE_W          = 16;
  localparam int DOT_W            = 64;
  localparam int FRAC_W           = 10;
  localparam int EXP_W            = 5;
  localparam int MANT_W           = FRAC_W + 1;
  localparam int SHIFT_W          = 5;
  localparam int CMDQ_DEPTH       = 4;

  localparam int DEF_BLOCKS_PER_GROUP = 8;
  localparam int DEF_ACT_WIDTH        = 16;

  localparam logic [EXP_W-1:0] EXP_SPECIAL = 5'h1F;
  localparam logic [EXP_W-1:0] EXP_SUBNORM = 5'h00;

  localparam logic [DOT_W-1:0] DOT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DOT_W-1:0] DOT_MIN = 64'h8000_0000_0000_0000;

  // control part of a closed group handed from front to back
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               last;
    logic               short_grp;
  } cmd_ctl_t;

endpackage

[src/i5gsdp_front.sv]
module i5gsdp_front #(
  parameter int BLOCKS_PER_GROUP = i5gsdp_pkg::DEF_BLOCKS_PER_GROUP,
  parameter int ACT_WIDTH        = i5gsdp_pkg::DEF_ACT_WIDTH,
  parameter int GSUM_W           = ACT_WIDTH + 9
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [i5gsdp_pkg::WORD_W-1:0]         in_packed_weights,
  input  logic signed [ACT_WIDTH-1:0]           in_act [i5gsdp_pkg::WEIGHTS_PER_WORD],
  input  logic [i5gsdp_pkg::SCALE_W-1:0]        in_group_scale,
  input  logic                                  in_last,
  output logic                                  q_push,
  input  logic                                  q_full,
  output logic signed [GSUM_W-1:0]              q_gsum,
  output i5gsdp_pkg::cmd_ctl_t                  q_ctl
);

  localparam int NW     = i5gsdp_pkg::WEIGHTS_PER_WORD;
  localparam int WB     = i5gsdp_pkg::WEIGHT_BITS;
  localparam int PROD_W = ACT_WIDTH + WB;
  localparam int ITEM_W = ACT_WIDTH + 8;
  localparam int CNT_W  = $clog2(BLOCKS_PER_GROUP) + 1;

  logic [WB-1:0]              code [NW];
  logic signed [WB-1:0]       wt [NW];
  logic signed [PROD_W-1:0]   prod_nxt [NW];
  logic signed [PROD_W-1:0]   prod_r [NW];
  logic                       a_valid_r;
  logic [i5gsdp_pkg::SCALE_W-1:0] a_scale_r;
  logic                       a_last_r;
  logic signed [ITEM_W-1:0]   item_sum;
  logic signed [GSUM_W-1:0]   gsum_r;
  logic signed [GSUM_W-1:0]   gsum_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic                       close_full;
  logic                       close;
  logic                       b_adv;
  logic                       accept;

  // weight code minus sixteen is the code with its top bit flipped
  always_comb begin
    for (int k = 0; k < NW; k++) begin
      code[k]     = in_packed_weights[k*WB +: WB];
      wt[k]       = signed'({~code[k][WB-1], code[k][WB-2:0]});
      prod_nxt[k] = PROD_W'(wt[k]) * PROD_W'(in_act[k]);
    end
  end

  always_comb begin
    item_sum = '0;
    for (int k = 0; k < NW; k++) begin
      item_sum = item_sum + ITEM_W'(prod_r[k]);
    end
  end

  assign gsum_nxt   = gsum_r + GSUM_W'(item_sum);
  assign close_full = (cnt_r == CNT_W'(BLOCKS_PER_GROUP - 1));
  assign close      = close_full || a_last_r;
  assign b_adv      = a_valid_r && (!close || !q_full);
  assign in_full    = a_valid_r && !b_adv;
  assign accept     = in_push && !in_full;

  assign q_push          = a_valid_r && close && !q_full;
  assign q_gsum          = gsum_nxt;
  assign q_ctl.scale     = a_scale_r;
  assign q_ctl.last      = a_last_r;
  assign q_ctl.short_grp = a_last_r && !close_full;

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r    <= prod_nxt;
      a_scale_r <= in_group_scale;
      a_last_r  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      gsum_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (b_adv) begin
        a_valid_r <= 1'b0;
      end
      if (b_adv) begin
        if (close) begin
          gsum_r <= '0;
          cnt_r  <= '0;
        end else begin
          gsum_r <= gsum_nxt;
          cnt_r  <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

endmodule

[src/i5gsdp_cmdq.sv]
module i5gsdp_cmdq #(
  parameter int GSUM_W = 25,
  parameter int DEPTH  = i5gsdp_pkg::CMDQ_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic signed [GSUM_W-1:0]  push_gsum,
  input  i5gsdp_pkg::cmd_ctl_t      push_ctl,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [GSUM_W-1:0]  pop_gsum,
  output i5gsdp_pkg::cmd_ctl_t      pop_ctl
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [GSUM_W-1:0]   gsum_mem_r [DEPTH];
  i5gsdp_pkg::cmd_ctl_t       ctl_mem_r [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r;
  logic [PTR_W-1:0]           rd_ptr_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       do_push;
  logic                       do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_gsum = gsum_mem_r[rd_ptr_r];
  assign pop_ctl  = ctl_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      gsum_mem_r[wr_ptr_r] <= push_gsum;
      ctl_mem_r[wr_ptr_r]  <= push_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

[src/i5gsdp_back.sv]
module i5gsdp_back #(
  parameter int GSUM_W = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic signed [GSUM_W-1:0]            q_gsum,
  input  i5gsdp_pkg::cmd_ctl_t                q_ctl,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [i5gsdp_pkg::DOT_W-1:0] out_dot_value,
  output logic                                out_overflow,
  output logic                                out_bad_scale,
  output logic                                out_short_group
);

  localparam int DW    = i5gsdp_pkg::DOT_W;
  localparam int MW    = i5gsdp_pkg::MANT_W;
  localparam int FW    = i5gsdp_pkg::FRAC_W;
  localparam int EW    = i5gsdp_pkg::EXP_W;
  localparam int SW    = i5gsdp_pkg::SHIFT_W;
  localparam int PW    = GSUM_W + MW;
  localparam int SH_W  = (PW + 30 > DW) ? PW + 30 : DW + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_SCALE = 5'b00100,
    S_ADD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                       state_r;
  state_t                       state_nxt;
  logic signed [GSUM_W-1:0]     gsum_r;
  i5gsdp_pkg::cmd_ctl_t         ctl_r;
  logic [EW-1:0]                expo;
  logic [MW-1:0]                mant;
  logic [GSUM_W-1:0]            mag;
  logic [PW-1:0]                prod_r;
  logic [SW-1:0]                shift_r;
  logic                         neg_r;
  logic                         bad_r;
  logic [SH_W-1:0]              shifted;
  logic [SH_W-1:0]              limit;
  logic signed [DW-1:0]         addend_r;
  logic signed [DW-1:0]         acc_r;
  logic signed [DW:0]           acc_sum;
  logic                         acc_ovf;
  logic                         ovf_seen_r;
  logic                         bad_seen_r;
  logic                         out_valid_r;
  logic                         emit;

  assign expo    = ctl_r.scale[FW +: EW];
  assign mant    = {(expo != i5gsdp_pkg::EXP_SUBNORM), ctl_r.scale[FW-1:0]};
  assign mag     = gsum_r[GSUM_W-1] ? GSUM_W'(-gsum_r) : GSUM_W'(gsum_r);
  assign shifted = SH_W'(prod_r) << shift_r;
  assign limit   = neg_r ? SH_W'(i5gsdp_pkg::DOT_MIN) : SH_W'(i5gsdp_pkg::DOT_MAX);
  assign acc_sum = {acc_r[DW-1], acc_r} + {addend_r[DW-1], addend_r};
  assign acc_ovf = acc_sum[DW] != acc_sum[DW-1];
  assign emit    = (state_r == S_EMIT) && (!out_valid_r || out_pop);
  assign q_pop   = (state_r == S_IDLE) && !q_empty;

  assign out_empty = !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_ADD;
      S_ADD:   state_nxt = ctl_r.last ? S_EMIT : S_IDLE;
      S_EMIT:  if (emit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (q_pop) begin
      gsum_r <= q_gsum;
      ctl_r  <= q_ctl;
    end
    if (state_r == S_MUL) begin
      prod_r  <= PW'(mag) * PW'(mant);
      shift_r <= (expo != i5gsdp_pkg::EXP_SUBNORM) ? SW'(expo - EW'(1)) : '0;
      neg_r   <= gsum_r[GSUM_W-1] != ctl_r.scale[FW + EW];
      bad_r   <= (expo == i5gsdp_pkg::EXP_SPECIAL);
    end
    if (state_r == S_SCALE) begin
      if (bad_r) begin
        addend_r <= '0;
      end else if (shifted > limit) begin
        addend_r <= neg_r ? signed'(i5gsdp_pkg::DOT_MIN) : signed'(i5gsdp_pkg::DOT_MAX);
      end else begin
        addend_r <= neg_r ? signed'(-shifted[DW-1:0]) : signed'(shifted[DW-1:0]);
      end
    end
    if (emit) begin
      out_dot_value   <= acc_r;
      out_overflow    <= ovf_seen_r;
      out_bad_scale   <= bad_seen_r;
      out_short_group <= ctl_r.short_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      ovf_seen_r  <= 1'b0;
      bad_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCALE) begin
        if (bad_r) begin
          bad_seen_r <= 1'b1;
        end else if (shifted > limit) begin
          ovf_seen_r <= 1'b1;
        end
      end
      if (state_r == S_ADD) begin
        if (acc_ovf) begin
          acc_r      <= acc_sum[DW] ? signed'(i5gsdp_pkg::DOT_MIN)
                                    : signed'(i5gsdp_pkg::DOT_MAX);
          ovf_seen_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[DW-1:0];
        end
      end
      if (emit) begin
        acc_r       <= '0;
        ovf_seen_r  <= 1'b0;
        bad_seen_r  <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[src/int5_group_scaled_dot_product.sv]
// Group-scaled int5 dot product.
//
// Input side is a queue: drive one packed word of eight 5-bit weights, the
// eight signed activations, the group's half-precision scale and last, and
// hold push high; the word is taken on an edge where full is low. Every
// BLOCKS_PER_GROUP words, or on a word with last set, the group sum is
// scaled exactly and added with saturation to the 64-bit accumulator; a bad scale adds zero.
// Result side is a queue too: one result word per vector, present while
// empty is low, taken on an edge where pop is high.
// A last word passes the front stage register, the group queue and the
// scaling unit's multiply, scale, add and emit states before empty goes
// low. Words are taken at one per cycle unless a closing word meets a full
// 4-entry group queue; each closed group holds the scaling unit through
// its take, multiply, scale and add states, plus emit when it ends a vector.
// A stalled result sits in the output register; the next vector keeps
// streaming in until its own result is ready to be stored.
// Reset (rst_n low, synchronous) clears the running sums, the sticky overflow and bad-scale flags and the queues.
module int5_group_scaled_dot_product #(
  parameter int BLOCKS_PER_GROUP = i5gsdp_pkg::DEF_BLOCKS_PER_GROUP,
  parameter int ACT_WIDTH        = i5gsdp_pkg::DEF_ACT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [i5gsdp_pkg::WORD_W-1:0]       in_packed_weights,
  input  logic signed [ACT_WIDTH-1:0]         in_act_0,
  input  logic signed [ACT_WIDTH-1:0]         in_act_1,
  input  logic signed [ACT_WIDTH-1:0]         in_act_2,
  input  logic signed [ACT_WIDTH-1:0]         in_act_3,
  input  logic signed [ACT_WIDTH-1:0]         in_act_4,
  input  logic signed [ACT_WIDTH-1:0]         in_act_5,
  input  logic signed [ACT_WIDTH-1:0]         in_act_6,
  input  logic signed [ACT_WIDTH-1:0]         in_act_7,
  input  logic [i5gsdp_pkg::SCALE_W-1:0]      in_group_scale,
  input  logic                                in_last,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [i5gsdp_pkg::DOT_W-1:0] out_dot_value,
  output logic                                out_overflow,
  output logic                                out_bad_scale,
  output logic                                out_short_group
);

  localparam int GSUM_W = ACT_WIDTH + 9 + $clog2(BLOCKS_PER_GROUP);

  logic signed [ACT_WIDTH-1:0] act [i5gsdp_pkg::WEIGHTS_PER_WORD];
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_empty;
  logic signed [GSUM_W-1:0]    q_push_gsum;
  logic signed [GSUM_W-1:0]    q_pop_gsum;
  i5gsdp_pkg::cmd_ctl_t        q_push_ctl;
  i5gsdp_pkg::cmd_ctl_t        q_pop_ctl;

  assign act[0] = in_act_0;
  assign act[1] = in_act_1;
  assign act[2] = in_act_2;
  assign act[3] = in_act_3;
  assign act[4] = in_act_4;
  assign act[5] = in_act_5;
  assign act[6] = in_act_6;
  assign act[7] = in_act_7;

  i5gsdp_front #(
    .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP),
    .ACT_WIDTH        (ACT_WIDTH),
    .GSUM_W           (GSUM_W)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_packed_weights (in_packed_weights),
    .in_act            (act),
    .in_group_scale    (in_group_scale),
    .in_last           (in_last),
    .q_push            (q_push),
    .q_full            (q_full),
    .q_gsum            (q_push_gsum),
    .q_ctl             (q_push_ctl)
  );

  i5gsdp_cmdq #(
    .GSUM_W (GSUM_W),
    .DEPTH  (i5gsdp_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .push_gsum (q_push_gsum),
    .push_ctl  (q_push_ctl),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_gsum  (q_pop_gsum),
    .pop_ctl   (q_pop_ctl)
  );

  i5gsdp_back #(
    .GSUM_W (GSUM_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_gsum          (q_pop_gsum),
    .q_ctl           (q_pop_ctl),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_dot_value   (out_dot_value),
    .out_overflow    (out_overflow),
    .out_bad_scale   (out_bad_scale),
    .out_short_group (out_short_group)
  );

  // group queue never overrun or underrun
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("group pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("group popped from empty queue");

  // result register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  // a closing word reaches the queue in the cycle it leaves the front stage
  a_last_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_push_ctl.last) |=> !q_empty)
    else $error("closing group lost");

endmodule
